@@ rtl/core/usm_pkg.sv @@
// Shared types and constants of the UV sphere mesh generator.
package usm_pkg;

   // Field widths
   localparam int ROW_W      = 9;
   localparam int COL_W      = 11;
   localparam int RAD_W      = 16;
   localparam int POS_W      = 17;
   localparam int NRM_W      = 16;
   localparam int TEX_W      = 17;
   localparam int VTX_W      = 19;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 192;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Divider geometry: numerator value*2^17 + count (value*2^16 for the polar angle), divisor 2*count
   localparam int DIV_NUM_W = 29;
   localparam int DIV_DEN_W = 12;
   localparam int DIV_LAT   = 17;

   // Sine/cosine pipeline depth
   localparam int SC_LAT = 9;

   // Register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RADIUS  = 2'd0,
      CSR_STACKS  = 2'd1,
      CSR_SECTORS = 2'd2
   } csr_idx_type;

   // Q2.30 constants
   localparam logic [31:0] PI_Q30  = 32'd3373259426;
   localparam logic [30:0] ONE_Q30 = 31'd1073741824;

   // Reciprocals for exact floor division of values below 2^30
   localparam int          SH_42  = 36;
   localparam logic [30:0] RCP_42 = 31'(((64'd1 << SH_42) + 64'd41) / 64'd42);
   localparam int          SH_20  = 35;
   localparam logic [30:0] RCP_20 = 31'(((64'd1 << SH_20) + 64'd19) / 64'd20);
   localparam int          SH_6   = 33;
   localparam logic [30:0] RCP_6  = 31'(((64'd1 << SH_6) + 64'd5) / 64'd6);
   localparam int          SH_30  = 35;
   localparam logic [30:0] RCP_30 = 31'(((64'd1 << SH_30) + 64'd29) / 64'd30);
   localparam int          SH_12  = 34;
   localparam logic [30:0] RCP_12 = 31'(((64'd1 << SH_12) + 64'd11) / 64'd12);

   // Per-item control that travels beside the arithmetic
   typedef struct packed {
      logic             valid;
      logic             func;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [1:0]       tri_mask;  // bit 0 upper triangle, bit 1 lower triangle
   } sb_type;

   // One result beat
   typedef struct packed {
      logic             last;
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [POS_W-1:0] pos_z;
      logic [NRM_W-1:0] norm_x;
      logic [NRM_W-1:0] norm_y;
      logic [NRM_W-1:0] norm_z;
      logic [TEX_W-1:0] tex_u;
      logic [TEX_W-1:0] tex_v;
      logic [VTX_W-1:0] vert_a;
      logic [VTX_W-1:0] vert_b;
      logic [VTX_W-1:0] vert_c;
   } beat_type;

endpackage

@@ rtl/core/usm_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
module usm_div #(
   parameter int NW = 29,
   parameter int DW = 12,
   parameter int QW = 17
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [QW-1:0] quo
);

   localparam int RW = ((NW > DW + QW) ? NW : DW + QW) + 1;

   logic [RW-1:0] rem_ff [QW-1];
   logic [DW-1:0] den_ff [QW-1];
   logic [QW-1:0] quo_ff [QW];

   for (genvar i = 0; i < QW; i++) begin : g_stage
      logic [RW-1:0] rem_prev;
      logic [DW-1:0] den_prev;
      logic [QW-1:0] quo_prev;
      logic [RW-1:0] sub;
      logic          ge;
      logic [RW-1:0] rem_in;
      logic [QW-1:0] quo_in;

      if (i == 0) begin : g_first
         assign rem_prev = RW'(num);
         assign den_prev = den;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign den_prev = den_ff[i-1];
         assign quo_prev = quo_ff[i-1];
      end

      // Trial subtract of the shifted divisor
      assign sub    = RW'(den_prev) << (QW - 1 - i);
      assign ge     = (rem_prev >= sub);
      assign rem_in = ge ? (rem_prev - sub) : rem_prev;
      assign quo_in = ge ? (quo_prev | (QW'(1) << (QW - 1 - i))) : quo_prev;

      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff[i] <= quo_in;
         end
      end

      if (i < QW - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[i] <= rem_in;
               den_ff[i] <= den_prev;
            end
         end
      end
   end

   assign quo = quo_ff[QW-1];

endmodule

@@ rtl/core/usm_sincos.sv @@
// Pipelined sine and cosine of a 16-bit turn fraction, Q1.14 results.
module usm_sincos (
   input  logic        clock,
   input  logic        en,
   input  logic [15:0] turn,
   output logic [15:0] sin_q,
   output logic [15:0] cos_q
);
   import usm_pkg::*;

   // Round Q2.30 to Q1.14, cap at one
   function automatic logic [15:0] to_q14(input logic [30:0] v);
      logic [31:0] s;
      logic [15:0] q;
      s = 32'(v) + 32'd32768;
      q = 16'(s >> 16);
      return (q > 16'd16384) ? 16'd16384 : q;
   endfunction

   // Octant fold and radian angle
   logic [13:0] f;
   logic        swap;
   logic [13:0] a;
   logic [45:0] ang;
   assign f    = turn[13:0];
   assign swap = (f > 14'd8192);
   assign a    = swap ? 14'(15'd16384 - {1'b0, f}) : f;
   assign ang  = 46'(a) * 46'(PI_Q30) + 46'd16384;

   logic [29:0] s1_r_ff;
   logic [2:0]  s1_oct_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         s1_r_ff   <= 30'(ang >> 15);
         s1_oct_ff <= {turn[15:14], swap};
      end
   end

   // Square of the angle
   logic [59:0] sq;
   assign sq = 60'(s1_r_ff) * 60'(s1_r_ff) + 60'd536870912;
   logic [29:0] s2_r_ff, s2_r2_ff;
   logic [2:0]  s2_oct_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         s2_r_ff   <= s1_r_ff;
         s2_r2_ff  <= 30'(sq >> 30);
         s2_oct_ff <= s1_oct_ff;
      end
   end

   // Innermost series terms
   logic [60:0] m3s, m3c;
   assign m3s = 61'(s2_r2_ff) * 61'(RCP_42);
   assign m3c = 61'(s2_r2_ff) * 61'(RCP_30);
   logic [29:0] s3_r_ff, s3_r2_ff, s3_qs_ff, s3_qc_ff;
   logic [2:0]  s3_oct_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         s3_r_ff   <= s2_r_ff;
         s3_r2_ff  <= s2_r2_ff;
         s3_qs_ff  <= 30'(m3s >> SH_42);
         s3_qc_ff  <= 30'(m3c >> SH_30);
         s3_oct_ff <= s2_oct_ff;
      end
   end

   // Horner step
   logic [30:0] t4s, t4c;
   logic [60:0] m4s, m4c;
   assign t4s = ONE_Q30 - 31'(s3_qs_ff);
   assign t4c = ONE_Q30 - 31'(s3_qc_ff);
   assign m4s = 61'(s3_r2_ff) * 61'(t4s);
   assign m4c = 61'(s3_r2_ff) * 61'(t4c);
   logic [29:0] s4_r_ff, s4_r2_ff, s4_ps_ff, s4_pc_ff;
   logic [2:0]  s4_oct_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         s4_r_ff   <= s3_r_ff;
         s4_r2_ff  <= s3_r2_ff;
         s4_ps_ff  <= 30'(m4s >> 30);
         s4_pc_ff  <= 30'(m4c >> 30);
         s4_oct_ff <= s3_oct_ff;
      end
   end

   // Divide by the next coefficients
   logic [60:0] m5s, m5c;
   assign m5s = 61'(s4_ps_ff) * 61'(RCP_20);
   assign m5c = 61'(s4_pc_ff) * 61'(RCP_12);
   logic [29:0] s5_r_ff, s5_r2_ff, s5_qs_ff, s5_qc_ff;
   logic [2:0]  s5_oct_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         s5_r_ff   <= s4_r_ff;
         s5_r2_ff  <= s4_r2_ff;
         s5_qs_ff  <= 30'(m5s >> SH_20);
         s5_qc_ff  <= 30'(m5c >> SH_12);
         s5_oct_ff <= s4_oct_ff;
      end
   end

   // Horner step
   logic [30:0] t6s, t6c;
   logic [60:0] m6s, m6c;
   assign t6s = ONE_Q30 - 31'(s5_qs_ff);
   assign t6c = ONE_Q30 - 31'(s5_qc_ff);
   assign m6s = 61'(s5_r2_ff) * 61'(t6s);
   assign m6c = 61'(s5_r2_ff) * 61'(t6c);
   logic [29:0] s6_r_ff, s6_ps_ff, s6_pc_ff;
   logic [2:0]  s6_oct_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         s6_r_ff   <= s5_r_ff;
         s6_ps_ff  <= 30'(m6s >> 30);
         s6_pc_ff  <= 30'(m6c >> 30);
         s6_oct_ff <= s5_oct_ff;
      end
   end

   // Last sine coefficient, finish cosine
   logic [60:0] m7s;
   assign m7s = 61'(s6_ps_ff) * 61'(RCP_6);
   logic [29:0] s7_r_ff, s7_qs_ff;
   logic [30:0] s7_cf_ff;
   logic [2:0]  s7_oct_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         s7_r_ff   <= s6_r_ff;
         s7_qs_ff  <= 30'(m7s >> SH_6);
         s7_cf_ff  <= ONE_Q30 - 31'(s6_pc_ff >> 1);
         s7_oct_ff <= s6_oct_ff;
      end
   end

   // Multiply sine series by the angle
   logic [30:0] t8s;
   logic [60:0] m8s;
   assign t8s = ONE_Q30 - 31'(s7_qs_ff);
   assign m8s = 61'(s7_r_ff) * 61'(t8s);
   logic [30:0] s8_sv_ff, s8_cf_ff;
   logic [2:0]  s8_oct_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         s8_sv_ff  <= 31'(m8s >> 30);
         s8_cf_ff  <= s7_cf_ff;
         s8_oct_ff <= s7_oct_ff;
      end
   end

   // Round, unfold octant and quadrant
   logic [15:0] qsv, qcv, fs, fc, sin_in, cos_in;
   assign qsv = to_q14(s8_sv_ff);
   assign qcv = to_q14(s8_cf_ff);
   assign fs  = s8_oct_ff[0] ? qcv : qsv;
   assign fc  = s8_oct_ff[0] ? qsv : qcv;
   always_comb begin
      unique case (s8_oct_ff[2:1])
         2'd0: begin sin_in = fs;  cos_in = fc;  end
         2'd1: begin sin_in = fc;  cos_in = -fs; end
         2'd2: begin sin_in = -fs; cos_in = -fc; end
         default: begin sin_in = -fc; cos_in = fs; end
      endcase
   end

   logic [15:0] sin_ff, cos_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_q = sin_ff;
   assign cos_q = cos_ff;

endmodule

@@ rtl/core/usm_delay.sv @@
// Enabled delay line with cleared stages at reset.
module usm_delay #(
   parameter int W     = 8,
   parameter int DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic [W-1:0] d,
   output logic [W-1:0] q
);

   logic [W-1:0] tap_ff [DEPTH];

   // Shift one place per advance
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) tap_ff[i] <= '0;
      end else if (en) begin
         tap_ff[0] <= d;
         for (int i = 1; i < DEPTH; i++) tap_ff[i] <= tap_ff[i-1];
      end
   end

   assign q = tap_ff[DEPTH-1];

endmodule

@@ rtl/core/uv_sphere_mesh_generator.sv @@
// Top level of the UV sphere mesh generator: vertex and quad triangle pipeline.
//
//  port group | direction | content
//  req_       | in        | one grid request per beat (func, row, col)
//  rsp_       | out       | vertex or triangle beats, tlast on the final one
//  csr_       | in        | register writes: radius, stack_count, sector_count
//
// One request enters per cycle while the output does not stall; a quad with both
// triangles holds the input while its second beat leaves. The pipeline holds the
// 17-stage quotient divider and the 9-stage sine/cosine series.
// Reset is synchronous, clears the pipeline valid bits and sets the config registers to their defaults.
// An output stall freezes the pipeline; a skid register keeps req_tready
// registered, so no beat is lost or repeated.
module uv_sphere_mesh_generator #(
   parameter int MAX_STACKS  = 256,
   parameter int MAX_SECTORS = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [usm_pkg::REQ_DATA_W-1:0]   req_tdata,   // row[8:0], col[19:9]
   input  logic                             req_tuser,   // func
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // pos_x[16:0], pos_y[33:17], pos_z[50:34], norm_x[66:51], norm_y[82:67],
   // norm_z[98:83], tex_u[115:99], tex_v[132:116], vert_a[151:133],
   // vert_b[170:152], vert_c[189:171]
   output logic [usm_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tlast,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [usm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [usm_pkg::CSR_DATA_W-1:0]   csr_data
);
   import usm_pkg::*;

   function automatic logic [ROW_W-1:0] clamp_stk(input logic [ROW_W-1:0] v);
      logic [ROW_W-1:0] r;
      if (v == '0) r = ROW_W'(1);
      else if (int'(v) > MAX_STACKS) r = ROW_W'(MAX_STACKS);
      else r = v;
      return r;
   endfunction

   function automatic logic [COL_W-1:0] clamp_sec(input logic [COL_W-1:0] v);
      logic [COL_W-1:0] r;
      if (v == '0) r = COL_W'(1);
      else if (int'(v) > MAX_SECTORS) r = COL_W'(MAX_SECTORS);
      else r = v;
      return r;
   endfunction

   // Signed product of two Q1.14 style values, rounded half away from zero
   function automatic logic signed [17:0] mul_q14(input logic signed [17:0] x,
                                                  input logic signed [17:0] y);
      logic        neg;
      logic [17:0] mx, my;
      logic [35:0] p;
      logic [17:0] q;
      neg = x[17] ^ y[17];
      mx  = x[17] ? 18'(-x) : 18'(x);
      my  = y[17] ? 18'(-y) : 18'(y);
      p   = 36'(mx) * 36'(my) + 36'd8192;
      q   = 18'(p >> 14);
      return neg ? $signed(-q) : $signed(q);
   endfunction

   // ---------------------------------------------------------------- config
   logic [RAD_W-1:0] radius_ff;
   logic [ROW_W-1:0] stacks_ff;
   logic [COL_W-1:0] sectors_ff;

   assign csr_ready = 1'b1;

   // Store clamped counts on write
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff  <= RAD_W'(256);
         stacks_ff  <= clamp_stk(ROW_W'(16));
         sectors_ff <= clamp_sec(COL_W'(32));
      end else if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_RADIUS:  radius_ff  <= csr_data;
            CSR_STACKS:  stacks_ff  <= clamp_stk(csr_data[ROW_W-1:0]);
            CSR_SECTORS: sectors_ff <= clamp_sec(csr_data[COL_W-1:0]);
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------- skid and S0
   logic             en;
   logic             skid_valid_ff;
   logic             skid_func_ff;
   logic [ROW_W-1:0] skid_row_ff;
   logic [COL_W-1:0] skid_col_ff;

   assign req_tready = !skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) skid_valid_ff <= 1'b0;
      else if (en) skid_valid_ff <= 1'b0;
      else if (req_tvalid) skid_valid_ff <= 1'b1;
   end

   // Park a beat taken while the pipeline is frozen
   always_ff @(posedge clock) begin
      if (!en && req_tvalid && req_tready) begin
         skid_func_ff <= req_tuser;
         skid_row_ff  <= req_tdata[ROW_W-1:0];
         skid_col_ff  <= req_tdata[ROW_W+COL_W-1:ROW_W];
      end
   end

   logic             src_valid, src_func, v_ok, q_ok;
   logic [ROW_W-1:0] src_row;
   logic [COL_W-1:0] src_col;
   logic [1:0]       src_mask;
   sb_type           sb0_in, sb0_ff;

   assign src_valid = skid_valid_ff | req_tvalid;
   assign src_func  = skid_valid_ff ? skid_func_ff : req_tuser;
   assign src_row   = skid_valid_ff ? skid_row_ff : req_tdata[ROW_W-1:0];
   assign src_col   = skid_valid_ff ? skid_col_ff : req_tdata[ROW_W+COL_W-1:ROW_W];

   // Range checks and pole triangle mask
   assign v_ok     = !src_func && (src_row <= stacks_ff) && (src_col <= sectors_ff);
   assign q_ok     = src_func && (src_row < stacks_ff) && (src_col < sectors_ff);
   assign src_mask = {src_row != (stacks_ff - ROW_W'(1)), src_row != '0};

   always_comb begin
      sb0_in.valid    = src_valid && (v_ok || (q_ok && src_mask != 2'b00));
      sb0_in.func     = src_func;
      sb0_in.row      = src_row;
      sb0_in.col      = src_col;
      sb0_in.tri_mask = src_mask;
   end

   always_ff @(posedge clock) begin
      if (reset) sb0_ff <= '0;
      else if (en) sb0_ff <= sb0_in;
   end

   // ------------------------------------------------------------- dividers
   logic [DIV_NUM_W-1:0] num_u, num_v, num_p;
   logic [DIV_DEN_W-1:0] den_u, den_s;
   logic [TEX_W-1:0]     tu_q, tv_q, phi_q;

   assign num_u = DIV_NUM_W'({sb0_ff.col, 17'd0}) + DIV_NUM_W'(sectors_ff);
   assign num_v = DIV_NUM_W'({sb0_ff.row, 17'd0}) + DIV_NUM_W'(stacks_ff);
   assign num_p = DIV_NUM_W'({sb0_ff.row, 16'd0}) + DIV_NUM_W'(stacks_ff);
   assign den_u = DIV_DEN_W'({sectors_ff, 1'b0});
   assign den_s = DIV_DEN_W'({stacks_ff, 1'b0});

   usm_div #(.NW(DIV_NUM_W), .DW(DIV_DEN_W), .QW(DIV_LAT)) u_div_u (
      .clock(clock), .en(en), .num(num_u), .den(den_u), .quo(tu_q));
   usm_div #(.NW(DIV_NUM_W), .DW(DIV_DEN_W), .QW(DIV_LAT)) u_div_v (
      .clock(clock), .en(en), .num(num_v), .den(den_s), .quo(tv_q));
   usm_div #(.NW(DIV_NUM_W), .DW(DIV_DEN_W), .QW(DIV_LAT)) u_div_p (
      .clock(clock), .en(en), .num(num_p), .den(den_s), .quo(phi_q));

   // -------------------------------------------------------------- sin/cos
   logic [NRM_W-1:0] sp, cp, st, ct;

   usm_sincos u_sc_phi (.clock(clock), .en(en), .turn(phi_q[15:0]), .sin_q(sp), .cos_q(cp));
   usm_sincos u_sc_th  (.clock(clock), .en(en), .turn(tu_q[15:0]),  .sin_q(st), .cos_q(ct));

   // Align texture coordinates and control with the series
   logic [2*TEX_W-1:0] tex_d;
   sb_type             sb_d;

   usm_delay #(.W(2*TEX_W), .DEPTH(SC_LAT)) u_dly_tex (
      .clock(clock), .reset(reset), .en(en), .d({tu_q, tv_q}), .q(tex_d));
   usm_delay #(.W($bits(sb_type)), .DEPTH(DIV_LAT + SC_LAT)) u_dly_sb (
      .clock(clock), .reset(reset), .en(en), .d(sb0_ff), .q(sb_d));

   // ------------------------------------------------------ normals, corner
   sb_type             m1_sb_ff;
   logic [NRM_W-1:0]   m1_nx_ff, m1_ny_ff, m1_nz_ff;
   logic [2*TEX_W-1:0] m1_tex_ff;
   logic [VTX_W-1:0]   m1_tl_ff;
   logic [21:0]        tl_full;

   assign tl_full = 22'(sb_d.row) * 22'(12'(sectors_ff) + 12'd1) + 22'(sb_d.col);

   always_ff @(posedge clock) begin
      if (reset) m1_sb_ff <= '0;
      else if (en) m1_sb_ff <= sb_d;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_nx_ff  <= NRM_W'(mul_q14(18'($signed(ct)), 18'($signed(sp))));
         m1_ny_ff  <= cp;
         m1_nz_ff  <= NRM_W'(mul_q14(18'($signed(st)), 18'($signed(sp))));
         m1_tex_ff <= tex_d;
         m1_tl_ff  <= VTX_W'(tl_full);
      end
   end

   // ----------------------------------------------------- position, quad
   sb_type             m2_sb_ff;
   logic [POS_W-1:0]   m2_px_ff, m2_py_ff, m2_pz_ff;
   logic [NRM_W-1:0]   m2_nx_ff, m2_ny_ff, m2_nz_ff;
   logic [2*TEX_W-1:0] m2_tex_ff;
   logic [VTX_W-1:0]   m2_tl_ff, m2_bl_ff, m2_tr_ff, m2_br_ff;
   logic signed [17:0] rad_s;
   logic [VTX_W-1:0]   bl_in;

   assign rad_s = $signed({2'b00, radius_ff});
   assign bl_in = m1_tl_ff + VTX_W'(sectors_ff) + VTX_W'(1);

   always_ff @(posedge clock) begin
      if (reset) m2_sb_ff <= '0;
      else if (en) m2_sb_ff <= m1_sb_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m2_px_ff  <= POS_W'(mul_q14(rad_s, 18'($signed(m1_nx_ff))));
         m2_py_ff  <= POS_W'(mul_q14(rad_s, 18'($signed(m1_ny_ff))));
         m2_pz_ff  <= POS_W'(mul_q14(rad_s, 18'($signed(m1_nz_ff))));
         m2_nx_ff  <= m1_nx_ff;
         m2_ny_ff  <= m1_ny_ff;
         m2_nz_ff  <= m1_nz_ff;
         m2_tex_ff <= m1_tex_ff;
         m2_tl_ff  <= m1_tl_ff;
         m2_bl_ff  <= bl_in;
         m2_tr_ff  <= m1_tl_ff + VTX_W'(1);
         m2_br_ff  <= bl_in + VTX_W'(1);
      end
   end

   // ------------------------------------------------------------- output
   beat_type first_in, second_in, out_beat_ff, pend_beat_ff;
   logic     out_valid_ff, pend_ff;

   // Build the first beat and, for a full quad, the lower triangle
   always_comb begin
      first_in  = '0;
      second_in = '0;
      second_in.last   = 1'b1;
      second_in.vert_a = m2_tr_ff;
      second_in.vert_b = m2_bl_ff;
      second_in.vert_c = m2_br_ff;
      if (!m2_sb_ff.func) begin
         first_in.last   = 1'b1;
         first_in.pos_x  = m2_px_ff;
         first_in.pos_y  = m2_py_ff;
         first_in.pos_z  = m2_pz_ff;
         first_in.norm_x = m2_nx_ff;
         first_in.norm_y = m2_ny_ff;
         first_in.norm_z = m2_nz_ff;
         first_in.tex_u  = m2_tex_ff[2*TEX_W-1:TEX_W];
         first_in.tex_v  = m2_tex_ff[TEX_W-1:0];
      end else if (m2_sb_ff.tri_mask[0]) begin
         first_in.last   = !m2_sb_ff.tri_mask[1];
         first_in.vert_a = m2_tl_ff;
         first_in.vert_b = m2_bl_ff;
         first_in.vert_c = m2_tr_ff;
      end else begin
         first_in = second_in;
      end
   end

   // Freeze the pipeline while a beat waits or a second triangle is queued
   assign en = !pend_ff && (!out_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else if (en) begin
         out_valid_ff <= m2_sb_ff.valid;
         pend_ff      <= m2_sb_ff.valid && m2_sb_ff.func && (m2_sb_ff.tri_mask == 2'b11);
      end else if (rsp_tready) begin
         pend_ff      <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_beat_ff  <= first_in;
         pend_beat_ff <= second_in;
      end else if (pend_ff && rsp_tready) begin
         out_beat_ff  <= pend_beat_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_beat_ff.last;
   assign rsp_tdata  = {2'b00,
                        out_beat_ff.vert_c, out_beat_ff.vert_b, out_beat_ff.vert_a,
                        out_beat_ff.tex_v,  out_beat_ff.tex_u,
                        out_beat_ff.norm_z, out_beat_ff.norm_y, out_beat_ff.norm_x,
                        out_beat_ff.pos_z,  out_beat_ff.pos_y,  out_beat_ff.pos_x};

endmodule

@@ rtl/core/usm_checker.sv @@
// Port-level checks of the UV sphere mesh generator and their binding.
module usm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [usm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tlast
);

   // Hold a stalled beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   // Drop all results at reset
   a_rsp_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat valid after reset");

   // A non-final beat is only ever the upper triangle of a quad
   a_first_tri: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[132:0] == '0)
      else $error("non-final beat carries vertex fields");

   // The lower triangle follows its upper triangle at once
   a_second_tri: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && rsp_tlast)
      else $error("second triangle not ready after first");

endmodule

bind uv_sphere_mesh_generator usm_checker u_usm_checker (.*);
